// ===== design/drl_pkg.sv =====
// shared types and constants for the digit run-length replacer
package drl_pkg;

	// byte and counter widths
	localparam int CHAR_W      = 8;
	localparam int RUN_W       = 13;
	localparam int RUN_SAT     = 8191;
	localparam int MAX_RUN_DEF = 4096;

	// count digits: four bcd digits cover any 13-bit count
	localparam int BCD_DIGITS = 4;
	localparam int DIGITS_W   = 4 * BCD_DIGITS;
	localparam int NDIG_W     = $clog2(BCD_DIGITS + 1);

	// character codes
	localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;
	localparam logic [3:0]        ASCII_DIGIT_HI = 4'h3;

	// run counter status handed to the emitter
	typedef struct packed {
		logic              pending;
		logic [NDIG_W-1:0] ndig;
		logic [DIGITS_W-1:0] digits;
	} drl_run_t;

endpackage

// ===== design/drl_if.sv =====
// valid/ready channel interfaces for input bytes and result bytes
interface drl_in_if import drl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] in_char;

	modport source (output valid, output in_char, input ready);
	modport sink   (input valid, input in_char, output ready);
endinterface

interface drl_out_if import drl_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              end_of_string;

	modport source (output valid, output out_char, output end_of_string, input ready);
	modport sink   (input valid, input out_char, input end_of_string, output ready);
endinterface

// ===== design/drl_run_counter.sv =====
// saturating run counter kept both in binary and in bcd
module drl_run_counter import drl_pkg::*; #(
	parameter int MAX_RUN = MAX_RUN_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     inc,
	input  logic     clr,
	output drl_run_t status
);

	localparam int RunCap   = (MAX_RUN > RUN_SAT) ? RUN_SAT : MAX_RUN;
	localparam int RunLimit = (RunCap < 1) ? 1 : RunCap;

	logic [RUN_W-1:0]    run_q;
	logic [DIGITS_W-1:0] bcd_q;
	logic [DIGITS_W-1:0] bcd_next;
	logic                below_limit;

	assign below_limit = (run_q < RUN_W'(RunLimit));

	// bcd increment, ripple carry over the digits
	always_comb begin
		logic carry;
		logic [3:0] d;
		carry    = 1'b1;
		bcd_next = bcd_q;
		for (int i = 0; i < BCD_DIGITS; i++) begin
			d = bcd_q[4*i +: 4];
			if (carry) begin
				if (d == 4'd9) begin
					bcd_next[4*i +: 4] = 4'd0;
				end else begin
					bcd_next[4*i +: 4] = d + 4'd1;
					carry = 1'b0;
				end
			end
		end
	end

	// counter registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= '0;
			bcd_q <= '0;
		end else if (clr) begin
			run_q <= '0;
			bcd_q <= '0;
		end else if (inc && below_limit) begin
			run_q <= run_q + RUN_W'(1);
			bcd_q <= bcd_next;
		end
	end

	// digit count and left alignment so the leading digit sits on top
	always_comb begin
		status.pending = (run_q != '0);
		if (bcd_q[15:12] != 4'd0) begin
			status.ndig   = NDIG_W'(4);
			status.digits = bcd_q;
		end else if (bcd_q[11:8] != 4'd0) begin
			status.ndig   = NDIG_W'(3);
			status.digits = {bcd_q[11:0], 4'd0};
		end else if (bcd_q[7:4] != 4'd0) begin
			status.ndig   = NDIG_W'(2);
			status.digits = {bcd_q[7:0], 8'd0};
		end else begin
			status.ndig   = NDIG_W'(1);
			status.digits = {bcd_q[3:0], 12'd0};
		end
	end

endmodule

// ===== design/digit_run_length_to_decimal.sv =====
// top level: replaces each run of decimal digits by its length in decimal
//
// Usage:
//   chars  : input beats, one byte each (in_char); a zero byte ends a string.
//   result : output beats, one byte each (out_char) plus end_of_string,
//            which is set only on the terminating zero byte.
//   A digit byte produces no beat; it bumps a run counter that saturates at
//   the smaller of MAX_RUN and 8191. Any other byte first releases the
//   pending count as one to four ascii digits, then the byte itself.
// Throughput: one input beat per cycle for digits and for bytes that close
//   no run, while result.ready is high. A byte that closes a run occupies
//   the emitter for one output beat per count digit plus one for the byte,
//   during which chars.ready is low until the cycle that moves the byte itself;
//   the emitter hands out one beat per cycle while result.ready is high.
// Order: a byte that closes no run goes through the pending register, then the
//   output register; a closed run puts its count digits out first, then the byte.
// Reset: arst_n clears the run counter and empties both registers.
// Stall: when the receiver holds result.ready low the output register keeps
//   its beat; input is still taken until the pending register is full.
module digit_run_length_to_decimal import drl_pkg::*; #(
	parameter int MAX_RUN = MAX_RUN_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	drl_in_if.sink    chars,
	drl_out_if.source result
);

	drl_run_t run_st;

	logic                is_digit;
	logic                take;
	logic                pop;

	logic                pend_valid_q;
	logic [NDIG_W-1:0]   pend_cnt_q;
	logic [DIGITS_W-1:0] pend_dig_q;
	logic [CHAR_W-1:0]   pend_char_q;
	logic                pend_eos_q;

	logic                out_valid_q;
	logic [CHAR_W-1:0]   out_char_q;
	logic                out_eos_q;

	// input decode and handshake
	assign is_digit    = (chars.in_char >= CHAR_ZERO) && (chars.in_char <= CHAR_NINE);
	assign take        = chars.valid && chars.ready;
	assign pop         = pend_valid_q && (!out_valid_q || result.ready);
	assign chars.ready = !pend_valid_q || (pop && (pend_cnt_q == '0));

	drl_run_counter #(
		.MAX_RUN(MAX_RUN)
	) u_cnt (
		.clk    (clk),
		.arst_n (arst_n),
		.inc    (take && is_digit),
		.clr    (take && !is_digit),
		.status (run_st)
	);

	// pending register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_cnt_q   <= '0;
		end else if (take && !is_digit) begin
			pend_valid_q <= 1'b1;
			pend_cnt_q   <= run_st.pending ? run_st.ndig : '0;
		end else if (pop) begin
			if (pend_cnt_q != '0) begin
				pend_cnt_q <= pend_cnt_q - NDIG_W'(1);
			end else begin
				pend_valid_q <= 1'b0;
			end
		end
	end

	// pending register payload
	always_ff @(posedge clk) begin
		if (take && !is_digit) begin
			pend_dig_q  <= run_st.digits;
			pend_char_q <= chars.in_char;
			pend_eos_q  <= (chars.in_char == CHAR_NUL);
		end else if (pop && (pend_cnt_q != '0)) begin
			pend_dig_q <= {pend_dig_q[DIGITS_W-5:0], 4'd0};
		end
	end

	// output register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload: a count digit first, else the held byte
	always_ff @(posedge clk) begin
		if (pop) begin
			if (pend_cnt_q != '0) begin
				out_char_q <= {ASCII_DIGIT_HI, pend_dig_q[DIGITS_W-1 -: 4]};
				out_eos_q  <= 1'b0;
			end else begin
				out_char_q <= pend_char_q;
				out_eos_q  <= pend_eos_q;
			end
		end
	end

	assign result.valid         = out_valid_q;
	assign result.out_char      = out_char_q;
	assign result.end_of_string = out_eos_q;

endmodule

// ===== design/drl_checker.sv =====
// port-level checks for the digit run-length replacer, bound to the top level
module drl_port_checker import drl_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [CHAR_W-1:0] out_char,
	input logic              out_eos
);

	// the end flag rides only on the zero byte
	a_eos_is_nul: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_eos |-> out_char == CHAR_NUL)
		else $error("end flag on a nonzero byte");

	// a zero byte is only ever emitted as the terminator
	a_nul_is_eos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_char == CHAR_NUL) |-> out_eos)
		else $error("zero byte without end flag");

	// input back-pressure only while the emitter has work queued
	a_stall_has_output: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> out_valid)
		else $error("input stalled with no output pending");

	// a stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_char) && $stable(out_eos))
		else $error("output beat changed while stalled");

endmodule

bind digit_run_length_to_decimal drl_port_checker u_drl_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (chars.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_char  (result.out_char),
	.out_eos   (result.end_of_string)
);
